[rtl/rcl_pkg.sv]
`default_nettype none
package rcl_pkg;

	// list size and derived widths
	localparam int CAPACITY = 32;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CMP_W    = CNT_W + 2;

	// operation codes on func
	localparam logic [1:0] FN_ADD   = 2'd0;
	localparam logic [1:0] FN_DEL   = 2'd1;
	localparam logic [1:0] FN_GET   = 2'd2;
	localparam logic [1:0] FN_PRINT = 2'd3;

	// status codes
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_BADPOS = 2'd1;
	localparam logic [1:0] ST_FULL   = 2'd2;

	// what every cell does
	typedef enum logic [1:0] {
		CELL_HOLD = 2'd0,
		CELL_INS  = 2'd1,
		CELL_DEL  = 2'd2,
		CELL_ROT  = 2'd3
	} cell_op_t;

	typedef struct packed {
		cell_op_t         op;
		logic [IDX_W-1:0] idx;
		logic [IDX_W-1:0] last_idx;
	} cell_ctrl_t;

endpackage
`default_nettype wire

[rtl/rcl_cell.sv]
`default_nettype none
module rcl_cell (
	input  wire logic                     clk,
	input  wire rcl_pkg::cell_ctrl_t      ctrl,
	input  wire logic [rcl_pkg::IDX_W-1:0] cell_idx,
	input  wire logic [7:0]               from_left,
	input  wire logic [7:0]               from_right,
	input  wire logic [7:0]               from_head,
	input  wire logic [7:0]               ins_data,
	output logic [7:0]                    data_q
);
	import rcl_pkg::*;

	logic [7:0] data_d;

	// pick the next value from own, neighbors, head or new element
	always_comb begin
		data_d = data_q;
		unique case (ctrl.op)
			CELL_HOLD: data_d = data_q;
			CELL_INS: begin
				if (cell_idx == ctrl.idx) begin
					data_d = ins_data;
				end else if (cell_idx > ctrl.idx) begin
					data_d = from_left;
				end
			end
			CELL_DEL: begin
				if (cell_idx >= ctrl.idx) begin
					data_d = from_right;
				end
			end
			CELL_ROT: begin
				if (cell_idx == ctrl.last_idx) begin
					data_d = from_head;
				end else if (cell_idx < ctrl.last_idx) begin
					data_d = from_right;
				end
			end
			default: data_d = data_q;
		endcase
	end

	// entry storage
	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

endmodule
`default_nettype wire

[rtl/ranked_char_list_unit.sv]
// channel  | handshake         | payload
// ---------+-------------------+--------------------------------------
// in       | in_valid/in_stall | func, position, element
// out      | out_valid/out_stall | status, item, has_item, last_of_run
//
// add, delete and get are each done in the cell chain when accepted; one item
// per cycle while the output register drains.
// print: the accept cycle, then the chain rotates its live entries past the
// head cell, one entry per cycle while the output is not stalled, and returns
// to order; an empty list gives its result on acceptance.
// input stalls during print and while a stalled result waits in the output register.
// reset clears count and control; entries are undefined until written.
`default_nettype none
module ranked_char_list_unit (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [1:0] func,
	input  wire logic [5:0] position,
	input  wire logic [7:0] element,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [1:0]      status,
	output logic [7:0]      item,
	output logic            has_item,
	output logic            last_of_run
);
	import rcl_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE  = 2'b01,
		S_PRINT = 2'b10
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] rem_q;
	logic             out_valid_q;
	logic [1:0]       status_q;
	logic [7:0]       item_q;
	logic             has_item_q;
	logic             last_q;

	logic             in_fire;
	logic             load_ok;
	logic [CMP_W-1:0] pos_w;
	logic [CMP_W-1:0] cnt_w;
	logic             rank_ok;
	logic             add_rank_ok;
	logic             full;
	logic [IDX_W-1:0] in_idx;
	cell_ctrl_t       ctrl;
	logic [7:0]       cell_q [CAPACITY];

	logic             res_load;
	logic [1:0]       res_status;
	logic [7:0]       res_item;
	logic             res_has;
	logic             res_last;

	assign load_ok  = !out_valid_q || !out_stall;
	assign in_stall = (state_q != S_IDLE) || !load_ok;
	assign in_fire  = in_valid && !in_stall;

	// rank checks
	assign pos_w       = CMP_W'(position);
	assign cnt_w       = CMP_W'(count_q);
	assign rank_ok     = (pos_w != '0) && (pos_w <= cnt_w);
	assign add_rank_ok = (pos_w != '0) && (pos_w <= cnt_w + CMP_W'(1));
	assign full        = (cnt_w >= CMP_W'(CAPACITY));
	assign in_idx      = IDX_W'(position - 6'd1);

	// chain control
	always_comb begin
		ctrl.op       = CELL_HOLD;
		ctrl.idx      = in_idx;
		ctrl.last_idx = IDX_W'(count_q - CNT_W'(1));
		priority if (state_q == S_PRINT && load_ok) begin
			ctrl.op = CELL_ROT;
		end else if (in_fire && func == FN_ADD && add_rank_ok && !full) begin
			ctrl.op = CELL_INS;
		end else if (in_fire && func == FN_DEL && rank_ok) begin
			ctrl.op = CELL_DEL;
		end
	end

	// row of cells
	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic [7:0] left_d;
		logic [7:0] right_d;
		if (g == 0) begin : g_first
			assign left_d = element;
		end else begin : g_mid_l
			assign left_d = cell_q[g-1];
		end
		if (g == CAPACITY - 1) begin : g_last
			assign right_d = 8'd0;
		end else begin : g_mid_r
			assign right_d = cell_q[g+1];
		end
		rcl_cell u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.cell_idx  (IDX_W'(g)),
			.from_left (left_d),
			.from_right(right_d),
			.from_head (cell_q[0]),
			.ins_data  (element),
			.data_q    (cell_q[g])
		);
	end

	// result for the output register
	always_comb begin
		res_load   = 1'b0;
		res_status = ST_OK;
		res_item   = 8'd0;
		res_has    = 1'b0;
		res_last   = 1'b1;
		if (state_q == S_PRINT) begin
			if (load_ok) begin
				res_load = 1'b1;
				res_item = cell_q[0];
				res_has  = 1'b1;
				res_last = (rem_q == CNT_W'(1));
			end
		end else if (in_fire) begin
			unique case (func)
				FN_ADD: begin
					res_load = 1'b1;
					if (!add_rank_ok) begin
						res_status = ST_BADPOS;
					end else if (full) begin
						res_status = ST_FULL;
					end
				end
				FN_DEL: begin
					res_load   = 1'b1;
					res_status = rank_ok ? ST_OK : ST_BADPOS;
				end
				FN_GET: begin
					res_load = 1'b1;
					if (rank_ok) begin
						res_item = cell_q[in_idx];
						res_has  = 1'b1;
					end else begin
						res_status = ST_BADPOS;
					end
				end
				FN_PRINT: begin
					res_load = (count_q == '0);
				end
				default: res_load = 1'b0;
			endcase
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rem_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (ctrl.op)
				CELL_INS: count_q <= count_q + CNT_W'(1);
				CELL_DEL: count_q <= count_q - CNT_W'(1);
				CELL_HOLD, CELL_ROT: count_q <= count_q;
				default: count_q <= count_q;
			endcase
			unique case (state_q)
				S_IDLE: begin
					if (in_fire && func == FN_PRINT && count_q != '0) begin
						state_q <= S_PRINT;
						rem_q   <= count_q;
					end
				end
				S_PRINT: begin
					if (load_ok) begin
						rem_q <= rem_q - CNT_W'(1);
						if (rem_q == CNT_W'(1)) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// output payload register
	always_ff @(posedge clk) begin
		if (res_load) begin
			status_q   <= res_status;
			item_q     <= res_item;
			has_item_q <= res_has;
			last_q     <= res_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign item        = item_q;
	assign has_item    = has_item_q;
	assign last_of_run = last_q;

	// checks
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		CMP_W'(count_q) <= CMP_W'(CAPACITY))
		else $error("count above capacity");

	a_print_live: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_PRINT |-> (rem_q != '0 && rem_q <= count_q))
		else $error("print run out of range");

	a_empty_print: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && func == FN_PRINT && count_q == '0
		|=> out_valid_q && last_q && !has_item_q && state_q == S_IDLE)
		else $error("empty print result missing");

	a_print_last: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_PRINT && load_ok && rem_q == CNT_W'(1)
		|=> state_q == S_IDLE && last_q)
		else $error("print did not close its run");

endmodule
`default_nettype wire
